// ----- rtl/wspc_pkg.sv -----
package wspc_pkg;

  localparam int unsigned WHEEL_MOD  = 210;
  localparam int unsigned WHEEL_RES  = 48;
  localparam int unsigned BASE_COUNT = 4;
  localparam int unsigned LIMIT_W    = 64;
  localparam int unsigned COUNT_W    = 40;

  // wheel residues coprime to 210
  function automatic logic [7:0] residue_f(input logic [5:0] idx);
    logic [7:0] r;
    unique case (idx)
      6'd0: r = 8'd1;    6'd1: r = 8'd11;   6'd2: r = 8'd13;   6'd3: r = 8'd17;
      6'd4: r = 8'd19;   6'd5: r = 8'd23;   6'd6: r = 8'd29;   6'd7: r = 8'd31;
      6'd8: r = 8'd37;   6'd9: r = 8'd41;   6'd10: r = 8'd43;  6'd11: r = 8'd47;
      6'd12: r = 8'd53;  6'd13: r = 8'd59;  6'd14: r = 8'd61;  6'd15: r = 8'd67;
      6'd16: r = 8'd71;  6'd17: r = 8'd73;  6'd18: r = 8'd79;  6'd19: r = 8'd83;
      6'd20: r = 8'd89;  6'd21: r = 8'd97;  6'd22: r = 8'd101; 6'd23: r = 8'd103;
      6'd24: r = 8'd107; 6'd25: r = 8'd109; 6'd26: r = 8'd113; 6'd27: r = 8'd121;
      6'd28: r = 8'd127; 6'd29: r = 8'd131; 6'd30: r = 8'd137; 6'd31: r = 8'd139;
      6'd32: r = 8'd143; 6'd33: r = 8'd149; 6'd34: r = 8'd151; 6'd35: r = 8'd157;
      6'd36: r = 8'd163; 6'd37: r = 8'd167; 6'd38: r = 8'd169; 6'd39: r = 8'd173;
      6'd40: r = 8'd179; 6'd41: r = 8'd181; 6'd42: r = 8'd187; 6'd43: r = 8'd191;
      6'd44: r = 8'd193; 6'd45: r = 8'd197; 6'd46: r = 8'd199; 6'd47: r = 8'd209;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // distance from a residue to the next one
  function automatic logic [3:0] gap_f(input logic [5:0] idx);
    logic [3:0] g;
    unique case (idx)
      6'd0, 6'd46: g = 4'd10;
      6'd20, 6'd26: g = 4'd8;
      6'd5, 6'd7, 6'd11, 6'd12, 6'd14, 6'd17, 6'd19, 6'd27, 6'd29, 6'd32, 6'd34,
      6'd35, 6'd39, 6'd41: g = 4'd6;
      6'd2, 6'd4, 6'd8, 6'd10, 6'd15, 6'd18, 6'd21, 6'd23, 6'd25, 6'd28, 6'd31,
      6'd36, 6'd38, 6'd42, 6'd44: g = 4'd4;
      default: g = 4'd2;
    endcase
    return g;
  endfunction

endpackage

// ----- rtl/wspc_ram.sv -----
module wspc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/wheel_segmented_prime_counter_top.sv -----
// wheel-210 segmented prime counter
// in channel: in_valid / in_stall, payload in_limit (64 bits). out channel:
// out_valid / out_stall, payload out_prime_count (40 bits) and out_too_large.
// one beat in gives one beat out. a limit above (BLOCK_SIZE*210)^2 is answered
// in the cycle after its beat is taken, with count 0 and too_large set.
// otherwise the block works one limit at a time. the bulk of state is in memories:
// a candidate bitmap of BLOCK_SIZE*210 bits (one entry per cycle) and a
// sieving-prime table (prime, next multiple, wheel position).
// work per limit, roughly: one full map clear per segment, one strike per
// multiple plus a table read, load and write-back per table entry per segment,
// and a read and a check per wheel residue counted. a table build pass over
// the first span comes first: a full clear, a read and a check per candidate,
// and per sieving prime one square check, its strikes and one exit step.
// the rate is set by the bitmap memory, with its one write and one read port.
// the result sits in an output register until taken; the next limit is taken
// only once the result has left. reset returns to idle with no result held.
module wheel_segmented_prime_counter_top
  import wspc_pkg::*;
#(
  parameter int BLOCK_SIZE        = 64,
  parameter int PRIME_TABLE_DEPTH = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [LIMIT_W-1:0] in_limit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COUNT_W-1:0] out_prime_count,
  output logic               out_too_large
);

  localparam longint SPAN  = longint'(BLOCK_SIZE) * WHEEL_MOD;
  localparam int     MAP_AW = $clog2(SPAN);
  localparam int     TAB_AW = (PRIME_TABLE_DEPTH > 1) ? $clog2(PRIME_TABLE_DEPTH) : 1;
  localparam int     NUM_W  = MAP_AW + 1;         // prime below 2*SPAN
  localparam int     MUL_W  = MAP_AW + 4;         // stored multiple, below 11*SPAN
  localparam int     CW     = MUL_W + 1;          // holds c + 10*p
  localparam int     JW     = $clog2(BLOCK_SIZE + 1);
  localparam int     ENT_W  = TAB_AW + 1;
  localparam int     TW     = NUM_W + MUL_W + 6;
  localparam int     SQ_W   = 2 * NUM_W;
  localparam logic [2*MAP_AW+1:0] SPAN_SQ = (2*MAP_AW+2)'(SPAN * SPAN);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_BCLR   = 4'd1;
  localparam logic [3:0] S_BRD    = 4'd2;   // read candidate p
  localparam logic [3:0] S_BCHK   = 4'd3;
  localparam logic [3:0] S_STRIKE = 4'd4;   // strike loop, shared
  localparam logic [3:0] S_SCLR   = 4'd5;
  localparam logic [3:0] S_TRD    = 4'd6;
  localparam logic [3:0] S_TLD    = 4'd7;
  localparam logic [3:0] S_TWB    = 4'd8;
  localparam logic [3:0] S_CRD    = 4'd9;
  localparam logic [3:0] S_CCHK   = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;
  localparam logic [3:0] S_PSQ    = 4'd12;

  logic [3:0]         st_r, st_nxt;
  logic [LIMIT_W-1:0] lim_r;
  logic [COUNT_W-1:0] cnt_r;
  logic               big_r;
  logic [MAP_AW-1:0]  clr_r;
  logic [JW-1:0]      j_r;
  logic [5:0]         i_r;
  logic [NUM_W-1:0]   p_r;
  logic [CW-1:0]      c_r;
  logic [5:0]         m_r;
  logic [ENT_W-1:0]   ent_r, e_r;
  logic               build_r;     // strike loop returns to build scan
  logic [LIMIT_W-1:0] segbase_r;   // 210*BLOCK_SIZE*segment
  logic [LIMIT_W-1:0] base_r;      // segbase + 210*j
  logic               seg0_r;
  logic [SQ_W-1:0]    sq_r;

  logic               mwe;
  logic [MAP_AW-1:0]  mwa, mra;
  logic               mwd, mrd;
  logic               twe;
  logic [TAB_AW-1:0]  twa, tra;
  logic [TW-1:0]      twd, trd;

  wspc_ram #(.WIDTH(1), .DEPTH(int'(SPAN))) u_map (
    .clk(clk), .we(mwe), .waddr(mwa), .wdata(mwd), .raddr(mra), .rdata(mrd));

  // table entry: {prime, next multiple, wheel position}
  wspc_ram #(.WIDTH(TW), .DEPTH(PRIME_TABLE_DEPTH)) u_tab (
    .clk(clk), .we(twe), .waddr(twa), .wdata(twd), .raddr(tra), .rdata(trd));

  logic [MAP_AW-1:0] addr_ji;
  logic [LIMIT_W-1:0] n_ji;
  assign addr_ji = MAP_AW'(longint'(j_r) * WHEEL_MOD) + MAP_AW'(residue_f(i_r));
  assign n_ji    = base_r + LIMIT_W'(residue_f(i_r));

  logic c_in;
  assign c_in = (c_r < CW'(SPAN));

  always_comb begin
    st_nxt = st_r;
    mwe = 1'b0; mwa = clr_r; mwd = 1'b1; mra = addr_ji;
    twe = 1'b0; twa = e_r[TAB_AW-1:0]; tra = e_r[TAB_AW-1:0];
    twd = {p_r, c_r[MUL_W-1:0], m_r};
    unique case (st_r)
      S_IDLE: if (in_valid) st_nxt = (in_limit > LIMIT_W'(SPAN_SQ)) ? S_OUT : S_BCLR;
      S_BCLR, S_SCLR: begin
        mwe = 1'b1;
        mwd = !(clr_r == MAP_AW'(1) && (st_r == S_BCLR || seg0_r));
        if (clr_r == MAP_AW'(SPAN - 1)) st_nxt = (st_r == S_BCLR) ? S_BRD : S_TRD;
      end
      S_BRD: st_nxt = (j_r == JW'(BLOCK_SIZE)) ? S_SCLR : S_BCHK;
      S_BCHK: if (mrd) st_nxt = S_PSQ; else st_nxt = S_BRD;
      S_PSQ: st_nxt = (LIMIT_W'(sq_r) > lim_r) ? S_SCLR : S_STRIKE;
      S_STRIKE: begin
        mwa = c_r[MAP_AW-1:0]; mwd = 1'b0; mwe = c_in;
        if (!c_in) st_nxt = build_r ? S_BRD : S_TWB;
      end
      S_TRD: st_nxt = (e_r == ent_r) ? S_CRD : S_TLD;
      S_TLD: st_nxt = S_STRIKE;
      S_TWB: begin
        twe = 1'b1;
        twd = {p_r, MUL_W'(c_r - CW'(SPAN)), m_r};
        st_nxt = S_TRD;
      end
      S_CRD: st_nxt = S_CCHK;
      S_CCHK: begin
        mra = addr_ji;
        if (n_ji > lim_r) st_nxt = S_OUT;
        else if (i_r == 6'd47 && j_r == JW'(BLOCK_SIZE - 1)) st_nxt = S_SCLR;
        else st_nxt = S_CRD;
      end
      S_OUT: if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_BCHK && st_nxt == S_PSQ && ent_r < ENT_W'(PRIME_TABLE_DEPTH)) begin
      twe = 1'b1; twa = ent_r[TAB_AW-1:0];
      twd = {p_r, MUL_W'(p_r) * MUL_W'(11), 6'd1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    unique case (st_r)
      S_IDLE: if (in_valid) begin
        lim_r <= in_limit; clr_r <= '0; j_r <= '0; i_r <= '0; ent_r <= '0;
        big_r <= (in_limit > LIMIT_W'(SPAN_SQ)); cnt_r <= '0; build_r <= 1'b1;
        seg0_r <= 1'b1; segbase_r <= '0;
      end
      S_BCLR, S_SCLR: begin
        clr_r <= (clr_r == MAP_AW'(SPAN - 1)) ? '0 : clr_r + 1'b1;
        e_r <= '0; j_r <= '0; i_r <= '0; base_r <= segbase_r;
        cnt_r <= (st_r == S_SCLR && seg0_r) ? COUNT_W'(BASE_COUNT) : cnt_r;
        build_r <= 1'b0;
      end
      S_BRD: p_r <= NUM_W'(longint'(j_r) * WHEEL_MOD) + NUM_W'(residue_f(i_r));
      S_BCHK: begin
        if (i_r == 6'd47) begin i_r <= '0; j_r <= j_r + 1'b1; end
        else i_r <= i_r + 1'b1;
        sq_r <= SQ_W'(p_r) * SQ_W'(p_r);
        c_r <= CW'(p_r) * CW'(11); m_r <= 6'd1;
        if (mrd) build_r <= 1'b1;
      end
      S_PSQ: if (LIMIT_W'(sq_r) <= lim_r && ent_r < ENT_W'(PRIME_TABLE_DEPTH))
        ent_r <= ent_r + 1'b1;
      S_STRIKE: if (c_in) begin
        c_r <= c_r + CW'(gap_f(m_r)) * CW'(p_r);
        m_r <= (m_r == 6'd47) ? 6'd0 : m_r + 1'b1;
      end
      S_TLD: begin
        p_r <= trd[TW-1 -: NUM_W]; c_r <= CW'(trd[6 +: MUL_W]); m_r <= trd[5:0];
      end
      S_TWB: e_r <= e_r + 1'b1;
      S_CCHK: begin
        if (n_ji <= lim_r && mrd) cnt_r <= cnt_r + 1'b1;
        if (i_r == 6'd47) begin
          i_r <= '0; j_r <= j_r + 1'b1; base_r <= base_r + LIMIT_W'(WHEEL_MOD);
          if (j_r == JW'(BLOCK_SIZE - 1)) begin
            segbase_r <= segbase_r + LIMIT_W'(SPAN); seg0_r <= 1'b0;
          end
        end else i_r <= i_r + 1'b1;
      end
      default: ;
    endcase
    if (st_r == S_PSQ && LIMIT_W'(sq_r) > lim_r) build_r <= 1'b0;
  end

  // residues rise within a row, so counting stops at the first one past the limit
  assign in_stall        = (st_r != S_IDLE);
  assign out_valid       = (st_r == S_OUT);
  assign out_prime_count = big_r ? '0 : cnt_r;
  assign out_too_large   = big_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_prime_count))
    else $error("result changed while held");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result held");

  a_big: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_large |-> out_prime_count == '0)
    else $error("too_large with nonzero count");

endmodule
